FILE: hw/rtl/estm_pkg.sv
// estm_pkg: shared types and constants of the escape sequence trie matcher.
// No dependencies; imported by escape_sequence_trie_matcher.

package estm_pkg;

    // Default node store depth (root included)
    localparam int NODE_COUNT_DEF = 256;

    // Function codes of an input item
    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_MATCH = 2'd2
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_MATCH  = 2'd1,
        ST_NEED_MORE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_LINK,
        S_RESULT
    } state_t;

endpackage

FILE: hw/rtl/estm_ram.sv
// estm_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies; used for the node store of escape_sequence_trie_matcher.

module estm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds data when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/escape_sequence_trie_matcher.sv
// escape_sequence_trie_matcher: longest-prefix byte-sequence trie matcher.
// Depends on estm_pkg and estm_ram (node store).
//
// The block keeps a trie of byte sequences: each node holds a byte, first-child
// and next-sibling links, a leaf flag, a key and a modifier. Clear items reset it
// to a bare root, add items insert one byte each and tag the end node on the last
// item, match items walk it one byte each and the last one reports the deepest
// leaf. Nodes live in a single RAM with one write and one read port; the root is
// held in flip-flops, so there is no clearing pass after reset or clear. Steps
// per item: clear, func 3 and items without a byte do no node read; an item with
// a byte reads the child list one sibling at a time (each node read is one
// registered RAM access), then an add that appends a node writes the link back;
// a last item then loads the result register and, on an add, tags the leaf.
// Results sit in an output register, so the next item is accepted while a result
// waits; a new result waits for that register to empty.

module escape_sequence_trie_matcher import estm_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    input  logic [15:0] entry_key,
    input  logic [7:0]  entry_mod,
    // result item channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  consumed_len,
    output logic [15:0] match_key,
    output logic [7:0]  match_mod,
    output logic        key_valid
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = AW + 1;

    typedef struct packed {
        logic [7:0]    chr;
        logic [AW-1:0] child;
        logic [AW-1:0] sibling;
        logic          leaf;
        logic [15:0]   key;
        logic [7:0]    mod_bits;
    } node_t;

    localparam int NW = $bits(node_t);

    // Sequencer
    state_t state_reg, state_next;

    // Latched item
    func_t       func_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [15:0] key_reg;
    logic [7:0]  mod_reg;

    // Search and append bookkeeping
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] prev_reg, prev_next;
    node_t         prev_word_reg, prev_word_next;
    logic [AW-1:0] new_reg, new_next;

    // Store and walk state
    logic [CW-1:0] node_count_reg, node_count_next;
    logic [AW-1:0] walk_node_reg, walk_node_next;
    node_t         walk_word_reg, walk_word_next;
    logic [AW-1:0] root_child_reg, root_child_next;
    logic          root_leaf_reg, root_leaf_next;
    logic [15:0]   root_key_reg, root_key_next;
    logic [7:0]    root_mod_reg, root_mod_next;
    logic [7:0]    byte_pos_reg, byte_pos_next;
    logic          leaf_seen_reg, leaf_seen_next;
    logic [7:0]    leaf_depth_reg, leaf_depth_next;
    logic [15:0]   leaf_key_reg, leaf_key_next;
    logic [7:0]    leaf_mod_reg, leaf_mod_next;
    logic          more_below_reg, more_below_next;
    logic          stopped_reg, stopped_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [7:0]  consumed_len_reg, consumed_len_next;
    logic [15:0] match_key_reg, match_key_next;
    logic [7:0]  match_mod_reg, match_mod_next;
    logic        key_valid_reg, key_valid_next;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    node_t         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    node_t         ram_rdata;
    logic [NW-1:0] ram_rdata_raw;

    // Helpers
    logic          accept;
    logic          do_miss;
    logic          do_hit;
    func_t         op_func;
    logic [7:0]    op_byte;
    logic          op_last;
    logic [AW-1:0] cur_child;
    logic          cur_leaf;
    logic [7:0]    pos_inc;
    node_t         fresh_word;
    node_t         sib_link_word;
    node_t         child_link_word;
    node_t         tag_word;

    // Node store
    estm_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    assign ram_rdata = node_t'(ram_rdata_raw);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Operand source: live inputs while idle, latched item afterwards
    assign op_func = (state_reg == S_IDLE) ? func_t'(func) : func_reg;
    assign op_byte = (state_reg == S_IDLE) ? data_byte : byte_reg;
    assign op_last = (state_reg == S_IDLE) ? last : last_reg;

    // Current walk node fields, root from flip-flops
    assign cur_child = (walk_node_reg == '0) ? root_child_reg : walk_word_reg.child;
    assign cur_leaf  = (walk_node_reg == '0) ? root_leaf_reg : walk_word_reg.leaf;

    assign pos_inc = (byte_pos_reg == 8'hFF) ? 8'hFF : byte_pos_reg + 8'd1;

    // Words written back to the store
    always_comb
    begin
        fresh_word     = '0;
        fresh_word.chr = op_byte;

        sib_link_word         = prev_word_reg;
        sib_link_word.sibling = new_reg;

        child_link_word       = walk_word_reg;
        child_link_word.child = new_reg;

        tag_word          = walk_word_reg;
        tag_word.leaf     = 1'b1;
        tag_word.key      = key_reg;
        tag_word.mod_bits = mod_reg;
    end

    // Next state and outputs
    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        prev_next         = prev_reg;
        prev_word_next    = prev_word_reg;
        new_next          = new_reg;
        node_count_next   = node_count_reg;
        walk_node_next    = walk_node_reg;
        walk_word_next    = walk_word_reg;
        root_child_next   = root_child_reg;
        root_leaf_next    = root_leaf_reg;
        root_key_next     = root_key_reg;
        root_mod_next     = root_mod_reg;
        byte_pos_next     = byte_pos_reg;
        leaf_seen_next    = leaf_seen_reg;
        leaf_depth_next   = leaf_depth_reg;
        leaf_key_next     = leaf_key_reg;
        leaf_mod_next     = leaf_mod_reg;
        more_below_next   = more_below_reg;
        stopped_next      = stopped_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        consumed_len_next = consumed_len_reg;
        match_key_next    = match_key_reg;
        match_mod_next    = match_mod_reg;
        key_valid_next    = key_valid_reg;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        ram_raddr         = '0;
        do_miss           = 1'b0;
        do_hit            = 1'b0;

        // Result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_next = '0;
                    unique case (func_t'(func))
                        FUNC_CLEAR:
                        begin
                            root_child_next = '0;
                            root_leaf_next  = 1'b0;
                            root_key_next   = '0;
                            root_mod_next   = '0;
                            node_count_next = CW'(1);
                            walk_node_next  = '0;
                            byte_pos_next   = '0;
                            leaf_seen_next  = 1'b0;
                            leaf_depth_next = '0;
                            leaf_key_next   = '0;
                            leaf_mod_next   = '0;
                            more_below_next = 1'b0;
                            stopped_next    = 1'b0;
                        end
                        FUNC_ADD, FUNC_MATCH:
                        begin
                            if (has_byte && !stopped_reg)
                            begin
                                if (cur_child == '0)
                                begin
                                    do_miss = 1'b1;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = cur_child;
                                    cur_next   = cur_child;
                                    state_next = S_SEARCH;
                                end
                            end
                            else if (last)
                            begin
                                state_next = S_RESULT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Walk the sibling list, one node read per cycle
            S_SEARCH:
            begin
                if (ram_rdata.chr == byte_reg)
                begin
                    do_hit = 1'b1;
                end
                else
                begin
                    prev_next      = cur_reg;
                    prev_word_next = ram_rdata;
                    if (ram_rdata.sibling == '0)
                    begin
                        do_miss = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ram_rdata.sibling;
                        cur_next  = ram_rdata.sibling;
                    end
                end
            end

            // Hook the appended node into its parent or sibling list
            S_LINK:
            begin
                if (prev_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_reg;
                    ram_wdata = sib_link_word;
                end
                else if (walk_node_reg == '0)
                begin
                    root_child_next = new_reg;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = walk_node_reg;
                    ram_wdata = child_link_word;
                end
                walk_node_next     = new_reg;
                walk_word_next     = '0;
                walk_word_next.chr = byte_reg;
                state_next         = last_reg ? S_RESULT : S_IDLE;
            end

            // Load the result register once it is free, tag the leaf on an add, reset the walk
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (func_reg == FUNC_ADD)
                    begin
                        status_next       = stopped_reg ? ST_FULL : ST_OK;
                        consumed_len_next = '0;
                        match_key_next    = '0;
                        match_mod_next    = '0;
                        key_valid_next    = 1'b0;
                        if (!stopped_reg && !cur_leaf)
                        begin
                            if (walk_node_reg == '0)
                            begin
                                root_leaf_next = 1'b1;
                                root_key_next  = key_reg;
                                root_mod_next  = mod_reg;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = walk_node_reg;
                                ram_wdata = tag_word;
                            end
                        end
                    end
                    else
                    begin
                        if (!stopped_reg && more_below_reg)
                        begin
                            status_next = ST_NEED_MORE;
                        end
                        else
                        begin
                            status_next = leaf_seen_reg ? ST_OK : ST_NO_MATCH;
                        end
                        consumed_len_next = leaf_seen_reg ? leaf_depth_reg : '0;
                        match_key_next    = leaf_seen_reg ? leaf_key_reg : '0;
                        match_mod_next    = leaf_seen_reg ? leaf_mod_reg : '0;
                        key_valid_next    = leaf_seen_reg;
                    end
                    walk_node_next  = '0;
                    prev_next       = '0;
                    byte_pos_next   = '0;
                    leaf_seen_next  = 1'b0;
                    leaf_depth_next = '0;
                    leaf_key_next   = '0;
                    leaf_mod_next   = '0;
                    more_below_next = 1'b0;
                    stopped_next    = 1'b0;
                    state_next      = S_IDLE;
                end
            end
        endcase

        // Byte not among the children: append (add) or stop (match / full store)
        if (do_miss)
        begin
            if (op_func == FUNC_ADD && node_count_reg < CW'(NODE_COUNT))
            begin
                ram_we          = 1'b1;
                ram_waddr       = node_count_reg[AW-1:0];
                ram_wdata       = fresh_word;
                new_next        = node_count_reg[AW-1:0];
                node_count_next = node_count_reg + CW'(1);
                state_next      = S_LINK;
            end
            else
            begin
                stopped_next = 1'b1;
                state_next   = op_last ? S_RESULT : S_IDLE;
            end
        end

        // Byte found: step down, track the deepest leaf on a match
        if (do_hit)
        begin
            walk_node_next = cur_reg;
            walk_word_next = ram_rdata;
            if (op_func == FUNC_MATCH)
            begin
                byte_pos_next   = pos_inc;
                more_below_next = (ram_rdata.child != '0);
                if (ram_rdata.leaf)
                begin
                    leaf_seen_next  = 1'b1;
                    leaf_depth_next = pos_inc;
                    leaf_key_next   = ram_rdata.key;
                    leaf_mod_next   = ram_rdata.mod_bits;
                end
            end
            state_next = op_last ? S_RESULT : S_IDLE;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CW'(1);
            walk_node_reg  <= '0;
            root_child_reg <= '0;
            root_leaf_reg  <= 1'b0;
            root_key_reg   <= '0;
            root_mod_reg   <= '0;
            byte_pos_reg   <= '0;
            leaf_seen_reg  <= 1'b0;
            leaf_depth_reg <= '0;
            leaf_key_reg   <= '0;
            leaf_mod_reg   <= '0;
            more_below_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            prev_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            walk_node_reg  <= walk_node_next;
            root_child_reg <= root_child_next;
            root_leaf_reg  <= root_leaf_next;
            root_key_reg   <= root_key_next;
            root_mod_reg   <= root_mod_next;
            byte_pos_reg   <= byte_pos_next;
            leaf_seen_reg  <= leaf_seen_next;
            leaf_depth_reg <= leaf_depth_next;
            leaf_key_reg   <= leaf_key_next;
            leaf_mod_reg   <= leaf_mod_next;
            more_below_reg <= more_below_next;
            stopped_reg    <= stopped_next;
            prev_reg       <= prev_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            byte_reg <= data_byte;
            last_reg <= last;
            key_reg  <= entry_key;
            mod_reg  <= entry_mod;
        end
        cur_reg          <= cur_next;
        prev_word_reg    <= prev_word_next;
        new_reg          <= new_next;
        walk_word_reg    <= walk_word_next;
        status_reg       <= status_next;
        consumed_len_reg <= consumed_len_next;
        match_key_reg    <= match_key_next;
        match_mod_reg    <= match_mod_next;
        key_valid_reg    <= key_valid_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign consumed_len = consumed_len_reg;
    assign match_key    = match_key_reg;
    assign match_mod    = match_mod_reg;
    assign key_valid    = key_valid_reg;

endmodule
